// ===== sv/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared constants and types of the preemptive priority scheduler
// Task table depth, field widths and the front to back request format.
// ----------------------------------------------------------------------------
package pps_pkg;
    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TIME_W    = 24;
    localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};
    localparam int QDEPTH    = 2;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    typedef struct packed {
        t_req        kind;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } t_cmd;
endpackage

// ===== sv/pps_front.sv =====
// ----------------------------------------------------------------------------
// pps_front: request intake
// Normalizes a load request (zero burst becomes one) and queues requests
// for the scheduling engine.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);
    t_cmd r_q [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd w_cmd;

    always_comb begin
        w_cmd = i_cmd;
        if (i_cmd.kind == REQ_LOAD && i_cmd.burst == 16'd0) begin
            w_cmd.burst = 16'd1;
        end
    end

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign n_cnt   = r_cnt + 2'(i_push && !o_full) - 2'(i_pop && o_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push && !o_full) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |=> r_cnt <= 2'd1) else $error("queue underflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'(QDEPTH)) |-> r_wp == r_rp)
        else $error("pointer mismatch");
endmodule

// ===== sv/pps_back.sv =====
// ----------------------------------------------------------------------------
// pps_back: scheduling engine
// Holds the task table in memories, scans it one entry per cycle to pick
// the best ready task, then updates that task and reports the tick.
// ----------------------------------------------------------------------------
module pps_back import pps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_strobe,
    output logic              o_ran_valid,
    output logic [5:0]        o_ran_index,
    output logic              o_finished,
    output logic [TIME_W-1:0] o_finish_time,
    output logic [TIME_W-1:0] o_turnaround,
    output logic [TIME_W-1:0] o_waiting,
    output logic [TIME_W-1:0] o_response,
    output logic [TIME_W-1:0] o_now_time,
    output logic              o_all_done,
    output logic              o_idle
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_LAST = 6'b000100,
        ST_RD   = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    // entry: arrival, burst, priority
    logic [39:0]       r_tab [MAX_TASKS];
    logic [15:0]       r_rem [MAX_TASKS];
    logic [TIME_W-1:0] r_st  [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_done;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count, r_dcnt;
    logic [TIME_W-1:0] r_clk;
    logic [CNT_W-1:0]  r_scan;
    logic [39:0]       r_ent;
    logic [IDX_W-1:0]  r_eidx;
    logic              r_found;
    logic [IDX_W-1:0]  r_best;
    logic [15:0]       r_barr, r_bbur;
    logic [7:0]        r_bpri;
    logic [15:0]       r_rrem;
    logic [TIME_W-1:0] r_rst;

    logic              w_ready, w_better;
    logic [TIME_W-1:0] n_clk, w_arr24, w_tat;
    logic [15:0]       n_rem;

    assign w_ready  = !r_done[r_eidx] && ({8'd0, r_ent[39:24]} <= r_clk);
    assign w_better = !r_found || (r_ent[7:0] > r_bpri) ||
                      (r_ent[7:0] == r_bpri && r_ent[39:24] < r_barr);
    assign n_clk    = (r_clk != CLOCK_MAX) ? r_clk + 1'b1 : r_clk;
    assign n_rem    = r_rrem - 16'd1;
    assign w_arr24  = {8'd0, r_barr};
    assign w_tat    = r_clk - w_arr24;
    assign o_pop    = (r_state == ST_IDLE) && i_valid;
    assign o_idle   = (r_state == ST_IDLE) && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_dcnt   <= '0;
            r_clk    <= '0;
            r_done   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.kind == REQ_LOAD) begin
                            if (r_count != CNT_W'(MAX_TASKS)) begin
                                r_tab[r_count[IDX_W-1:0]] <=
                                    {i_cmd.arrival, i_cmd.burst, i_cmd.prio};
                                r_rem[r_count[IDX_W-1:0]]  <= i_cmd.burst;
                                r_done[r_count[IDX_W-1:0]] <= 1'b0;
                                r_count <= r_count + 1'b1;
                            end
                        end else begin
                            r_found <= 1'b0;
                            r_scan  <= '0;
                            r_state <= (r_count == '0) ? ST_FIN : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_ent  <= r_tab[r_scan[IDX_W-1:0]];
                    r_eidx <= r_scan[IDX_W-1:0];
                    r_scan <= r_scan + 1'b1;
                    if (r_scan + 1'b1 == r_count) begin
                        r_state <= ST_LAST;
                    end
                    if (r_scan != '0 && w_ready && w_better) begin
                        r_found <= 1'b1;
                        r_best  <= r_eidx;
                        r_barr  <= r_ent[39:24];
                        r_bbur  <= r_ent[23:8];
                        r_bpri  <= r_ent[7:0];
                    end
                end
                ST_LAST: begin
                    if (w_ready && w_better) begin
                        r_found <= 1'b1;
                        r_best  <= r_eidx;
                        r_barr  <= r_ent[39:24];
                        r_bbur  <= r_ent[23:8];
                        r_bpri  <= r_ent[7:0];
                    end
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_rrem  <= r_rem[r_best];
                    r_rst   <= r_st[r_best];
                    r_state <= r_found ? ST_UPD : ST_FIN;
                end
                ST_UPD: begin
                    r_rem[r_best] <= n_rem;
                    if (r_rrem == r_bbur) begin
                        r_st[r_best] <= r_clk;
                        r_rst        <= r_clk;
                    end
                    r_rrem  <= n_rem;
                    r_clk   <= n_clk;
                    r_state <= ST_FIN;
                    if (n_rem == 16'd0) begin
                        r_done[r_best] <= 1'b1;
                        r_dcnt         <= r_dcnt + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (!r_found) begin
                        r_clk <= n_clk;
                    end
                    o_strobe    <= 1'b1;
                    o_ran_valid <= r_found;
                    o_ran_index <= r_found ? 6'(r_best) : 6'd0;
                    o_now_time  <= r_found ? r_clk : n_clk;
                    o_all_done  <= (r_dcnt == r_count);
                    o_finished  <= r_found && r_rrem == 16'd0;
                    if (r_found && r_rrem == 16'd0) begin
                        o_finish_time <= r_clk;
                        o_turnaround  <= w_tat;
                        o_waiting     <= (w_tat >= {8'd0, r_bbur}) ?
                                         w_tat - {8'd0, r_bbur} : '0;
                        o_response    <= r_rst - w_arr24;
                    end else begin
                        o_finish_time <= '0;
                        o_turnaround  <= '0;
                        o_waiting     <= '0;
                        o_response    <= '0;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_dcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= r_count) else $error("done count above task count");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_FIN)) else $error("stray result");
    a_clk_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_clk >= $past(r_clk)) else $error("clock went back");
endmodule

// ===== sv/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: top level
// Task table with priority selection, one request per load or tick.
// ----------------------------------------------------------------------------
// channel  | handshake       | payload
// request  | start/busy      | i_req_type, i_arrival_time, i_burst_time,
//          |                 | i_priority_req
// result   | o_strobe        | o_ran_valid .. o_all_done
// A load is written into the table from idle; a tick scans the task table
// memory one entry per cycle, then reads and updates the chosen task and
// reports the result (an empty table goes straight to the report).
// A two-entry queue lets a request be taken while a tick is running.
// Reset is synchronous; no clearing pass is needed. Results cannot stall.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [15:0]       i_arrival_time,
    input  logic [15:0]       i_burst_time,
    input  logic [7:0]        i_priority_req,
    output logic              o_strobe,
    output logic              o_ran_valid,
    output logic [5:0]        o_ran_index,
    output logic              o_finished,
    output logic [TIME_W-1:0] o_finish_time,
    output logic [TIME_W-1:0] o_turnaround,
    output logic [TIME_W-1:0] o_waiting,
    output logic [TIME_W-1:0] o_response,
    output logic [TIME_W-1:0] o_now_time,
    output logic              o_all_done
);
    t_cmd w_in, w_q;
    logic w_full, w_qv, w_pop, w_idle;

    assign w_in = '{kind: t_req'(i_req_type), arrival: i_arrival_time,
                    burst: i_burst_time, prio: i_priority_req};
    assign busy = w_full;

    pps_front u_front (
        .i_clk, .i_rst_n,
        .i_push (start), .i_cmd (w_in), .o_full (w_full),
        .o_valid (w_qv), .o_cmd (w_q), .i_pop (w_pop)
    );

    pps_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (w_qv), .i_cmd (w_q), .o_pop (w_pop),
        .o_strobe, .o_ran_valid, .o_ran_index, .o_finished,
        .o_finish_time, .o_turnaround, .o_waiting, .o_response,
        .o_now_time, .o_all_done, .o_idle (w_idle)
    );

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_idle) else $error("busy while engine idle");
    a_strobe_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(!w_idle)) else $error("result without request");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_finished |-> o_ran_valid) else $error("finish while idle");
endmodule

// ===== tb/tb_preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler: self-checking bench for the scheduler
// Loads task tables, issues ticks with random gaps and compares every
// tick result against a behavioral copy of the priority selection.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;
    import pps_pkg::*;

    typedef struct {
        logic              ran_valid;
        logic [5:0]        ran_index;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic [TIME_W-1:0] now_time;
        logic              all_done;
    } t_tick_res;

    int errors = 0;

    function automatic void report(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endfunction

    class sched_board;
        int unsigned n_tasks, n_done, clk_now;
        logic [15:0] arr[MAX_TASKS];
        logic [15:0] bur[MAX_TASKS];
        logic [7:0]  pri[MAX_TASKS];
        logic [15:0] rem[MAX_TASKS];
        int unsigned st[MAX_TASKS];
        bit          done[MAX_TASKS];
        t_tick_res   pending[$];

        function void note(t_req kind, logic [15:0] a, logic [15:0] b, logic [7:0] p);
            t_tick_res r;
            int best;
            int unsigned tat;
            best = -1;
            if (kind == REQ_LOAD) begin
                if (n_tasks < MAX_TASKS) begin
                    if (b == 0) b = 1;
                    arr[n_tasks] = a; bur[n_tasks] = b; pri[n_tasks] = p;
                    rem[n_tasks] = b; st[n_tasks] = 0; done[n_tasks] = 0;
                    n_tasks++;
                end
                return;
            end
            r = '{default: 0};
            for (int i = 0; i < n_tasks; i++) begin
                if (done[i] || arr[i] > clk_now) continue;
                if (best < 0 || pri[i] > pri[best] ||
                    (pri[i] == pri[best] && arr[i] < arr[best])) best = i;
            end
            if (best >= 0 && rem[best] == bur[best]) st[best] = clk_now;
            if (clk_now < CLOCK_MAX) clk_now++;
            if (best >= 0) begin
                r.ran_valid = 1;
                r.ran_index = best[5:0];
                rem[best]--;
                if (rem[best] == 0) begin
                    tat = clk_now - arr[best];
                    done[best] = 1;
                    n_done++;
                    r.finished = 1;
                    r.finish_time = TIME_W'(clk_now);
                    r.turnaround = TIME_W'(tat);
                    r.waiting = (tat >= bur[best]) ? TIME_W'(tat - bur[best]) : '0;
                    r.response = TIME_W'(st[best] - arr[best]);
                end
            end
            r.now_time = TIME_W'(clk_now);
            r.all_done = (n_done == n_tasks);
            pending.push_back(r);
        endfunction

        function void check(t_tick_res g);
            t_tick_res w;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (g.ran_valid !== w.ran_valid) report("ran_valid", g.ran_valid, w.ran_valid);
            if (g.ran_index !== w.ran_index) report("ran_index", g.ran_index, w.ran_index);
            if (g.finished !== w.finished) report("finished", g.finished, w.finished);
            if (g.finish_time !== w.finish_time) report("finish_time", g.finish_time, w.finish_time);
            if (g.turnaround !== w.turnaround) report("turnaround", g.turnaround, w.turnaround);
            if (g.waiting !== w.waiting) report("waiting", g.waiting, w.waiting);
            if (g.response !== w.response) report("response", g.response, w.response);
            if (g.now_time !== w.now_time) report("now_time", g.now_time, w.now_time);
            if (g.all_done !== w.all_done) report("all_done", g.all_done, w.all_done);
        endfunction
    endclass

    logic              i_clk = 0, i_rst_n = 0, start = 0;
    logic              busy;
    logic              i_req_type = 0;
    logic [15:0]       i_arrival_time = 0, i_burst_time = 0;
    logic [7:0]        i_priority_req = 0;
    logic              o_strobe, o_ran_valid, o_finished, o_all_done;
    logic [5:0]        o_ran_index;
    logic [TIME_W-1:0] o_finish_time, o_turnaround, o_waiting, o_response, o_now_time;

    sched_board sb = new();
    int         idle_pct = 16;

    preemptive_priority_scheduler uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check('{o_ran_valid, o_ran_index, o_finished, o_finish_time, o_turnaround,
                       o_waiting, o_response, o_now_time, o_all_done});
    end

    // start stays high across back-to-back requests; only one NBA per edge
    task automatic send(t_req kind, logic [15:0] a, logic [15:0] b, logic [7:0] p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_req_type <= kind;
        i_arrival_time <= a;
        i_burst_time <= b;
        i_priority_req <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note(kind, a, b, p);
    endtask

    task automatic go_idle();
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic load(logic [15:0] a, logic [15:0] b, logic [7:0] p);
        send(REQ_LOAD, a, b, p);
    endtask

    task automatic tick();
        send(REQ_TICK, $urandom, $urandom, $urandom);
    endtask

    int n;
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty ticks, zero burst, ties, late arrival, late load
        tick(); tick();
        load(16'd0, 16'd0, 8'd5);
        load(16'd1, 16'd3, 8'd5);
        load(16'd1, 16'd2, 8'hFF);
        load(16'd0, 16'd2, 8'd5);
        load(16'hFFFF, 16'hFFFF, 8'd0);
        repeat (8) tick();
        load(16'd0, 16'd1, 8'd0);
        repeat (4) tick();
        drain();

        // fill past capacity with short bursts
        for (int i = 0; i < MAX_TASKS + 3; i++)
            load($urandom_range(40), $urandom_range(3), $urandom);
        idle_pct = 0;
        repeat (150) tick();
        drain();
        idle_pct = 16;

        // random: late loads against the already full table, mostly ticks
        n = 0;
        while (n < 1300) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: load($urandom, $urandom, $urandom);
                    1: load(16'(sb.clk_now + $urandom_range(5)), 16'hFFFF, 8'hFF);
                    default: load(16'(sb.clk_now - $urandom_range(3)),
                                  $urandom_range(4), $urandom);
                endcase
            end else begin
                tick();
            end
            n++;
            if (n == 500) drain();
            idle_pct = (n > 700 && n < 900) ? 0 : 16;
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
